@@ rtl/cca_pkg.sv @@
`default_nettype none

package cca_pkg;

    // Store geometry.
    localparam int CELL_COUNT = 1024;
    localparam int OWNER_BITS = 16;
    localparam int ADDR_BITS  = $clog2(CELL_COUNT);
    // Wide enough for a run length of CELL_COUNT and for the scan terminator index.
    localparam int LEN_BITS   = ADDR_BITS + 1;

    // Fixed field widths of the request and result.
    localparam int ID_BITS    = 16;
    localparam int SIZE_BITS  = 11;
    localparam int START_BITS = 10;

    // Opcodes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_NO_ROOM   = 2'd1;
    localparam logic [1:0] STAT_BAD_SIZE  = 2'd2;
    localparam logic [1:0] STAT_BAD_OWNER = 2'd3;

    typedef struct packed {
        logic                 opcode;
        logic [ID_BITS-1:0]   owner_id;
        logic [SIZE_BITS-1:0] request_size;
    } cca_req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [START_BITS-1:0] start_cell;
    } cca_rsp_t;

    // One scanned cell handed to the run tracker.
    typedef struct packed {
        logic                valid;
        logic                free_cell;
        logic [LEN_BITS-1:0] index;
    } cca_step_t;

    // What the run tracker has chosen so far.
    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] start;
    } cca_pick_t;

endpackage

`default_nettype wire

@@ rtl/contiguous_cell_allocator.sv @@
`default_nettype none
// Allocate: accept, scan the store, pick a run, fill request_size cells, load the result.
// Clear: a read-compare-write pass over the store; rejected requests go straight to the result.
// One request at a time, bounded by the single read port of the cell store.
// Reset is synchronous, active low; after it a clearing pass over the CELL_COUNT (1024) cells
// frees every cell, with s_ready low meanwhile; configuration writes are taken throughout.

module contiguous_cell_allocator (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire cca_pkg::cca_req_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output cca_pkg::cca_rsp_t      m_data
);
    import cca_pkg::*;

    typedef enum logic [6:0] {
        ST_INIT = 7'b0000001,
        ST_IDLE = 7'b0000010,
        ST_SCAN = 7'b0000100,
        ST_PICK = 7'b0001000,
        ST_FILL = 7'b0010000,
        ST_CLR  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    localparam logic [LEN_BITS-1:0] CNT_LAST = LEN_BITS'(CELL_COUNT - 1);
    localparam logic [LEN_BITS-1:0] CNT_END  = LEN_BITS'(CELL_COUNT);
    localparam logic [LEN_BITS-1:0] CNT_STOP = LEN_BITS'(CELL_COUNT + 1);

    state_t                state_reg,      state_next;
    logic [LEN_BITS-1:0]   cnt_reg,        cnt_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [LEN_BITS-1:0]   pend_idx_reg,   pend_idx_next;
    logic [1:0]            fit_mode_reg,   fit_mode_next;
    logic [OWNER_BITS-1:0] owner_reg,      owner_next;
    logic [LEN_BITS-1:0]   want_reg,       want_next;
    logic [ADDR_BITS-1:0]  fill_addr_reg,  fill_addr_next;
    logic [LEN_BITS-1:0]   remain_reg,     remain_next;
    logic [1:0]            status_reg,     status_next;
    logic [ADDR_BITS-1:0]  start_reg,      start_next;
    logic                  m_valid_reg,    m_valid_next;
    cca_rsp_t              m_data_reg,     m_data_next;

    logic                  accept;
    logic                  size_bad;
    logic [OWNER_BITS-1:0] req_owner;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [OWNER_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [OWNER_BITS-1:0] rd_data;
    logic                  clr_hit;
    cca_step_t             step;
    cca_pick_t             pick;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign req_owner = OWNER_BITS'(s_data.owner_id);
    assign size_bad  = (s_data.request_size == '0) ||
                       (32'(s_data.request_size) > CELL_COUNT);

    // The cell store.
    cca_cell_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cnt_reg[ADDR_BITS-1:0]),
        .rd_data (rd_data)
    );

    // Cells read in the previous cycle feed the run tracker during a scan.
    assign step.valid     = pend_valid_reg && (state_reg == ST_SCAN);
    assign step.free_cell = (pend_idx_reg != CNT_END) && (rd_data == '0);
    assign step.index     = pend_idx_reg;

    cca_run_unit u_run (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .restart  (accept),
        .fit_mode (fit_mode_reg),
        .want     (want_reg),
        .step     (step),
        .pick     (pick)
    );

    // A cell read during a clear pass is freed when it holds the owner.
    assign clr_hit = (state_reg == ST_CLR) && pend_valid_reg && (rd_data == owner_reg);

    // Store write port: clearing pass, run fill or owner clear.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[ADDR_BITS-1:0];
        wr_data = '0;
        if (state_reg == ST_INIT) begin
            wr_en = 1'b1;
        end else if (state_reg == ST_FILL) begin
            wr_en   = 1'b1;
            wr_addr = fill_addr_reg;
            wr_data = owner_reg;
        end else if (clr_hit) begin
            wr_en   = 1'b1;
            wr_addr = pend_idx_reg[ADDR_BITS-1:0];
        end
    end

    assign rd_en = ((state_reg == ST_SCAN) && (cnt_reg < CNT_END)) ||
                   ((state_reg == ST_CLR) && (cnt_reg < CNT_END));

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = cnt_reg;
        fit_mode_next   = fit_mode_reg;
        owner_next      = owner_reg;
        want_next       = want_reg;
        fill_addr_next  = fill_addr_reg;
        remain_next     = remain_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cfg_wr_en) begin
            fit_mode_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_INIT: begin
                cnt_next = cnt_reg + LEN_BITS'(1);
                if (cnt_reg == CNT_LAST) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    owner_next  = req_owner;
                    want_next   = LEN_BITS'(s_data.request_size);
                    start_next  = '0;
                    status_next = STAT_DONE;
                    cnt_next    = '0;
                    if (req_owner == '0) begin
                        status_next = STAT_BAD_OWNER;
                        state_next  = ST_DONE;
                    end else if (s_data.opcode == OP_CLEAR) begin
                        state_next = ST_CLR;
                    end else if (size_bad) begin
                        status_next = STAT_BAD_SIZE;
                        state_next  = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Reads run one past the last cell so that a final run is closed.
                if (cnt_reg != CNT_STOP) begin
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + LEN_BITS'(1);
                end
                if (pend_valid_reg && (pend_idx_reg == CNT_END)) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (pick.found) begin
                    fill_addr_next = pick.start;
                    remain_next    = want_reg;
                    start_next     = pick.start;
                    state_next     = ST_FILL;
                end else begin
                    status_next = STAT_NO_ROOM;
                    state_next  = ST_DONE;
                end
            end
            ST_FILL: begin
                fill_addr_next = fill_addr_reg + ADDR_BITS'(1);
                remain_next    = remain_reg - LEN_BITS'(1);
                if (remain_reg == LEN_BITS'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_CLR: begin
                if (cnt_reg < CNT_END) begin
                    pend_valid_next = 1'b1;
                    cnt_next        = cnt_reg + LEN_BITS'(1);
                end
                if (pend_valid_reg && (pend_idx_reg == CNT_LAST)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Load the output register once the previous result has gone.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.start_cell = START_BITS'(start_reg);
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            fit_mode_reg   <= FIT_FIRST;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            fit_mode_reg   <= fit_mode_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_idx_reg  <= pend_idx_next;
        owner_reg     <= owner_next;
        want_reg      <= want_next;
        fill_addr_reg <= fill_addr_next;
        remain_reg    <= remain_next;
        status_reg    <= status_next;
        start_reg     <= start_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/cca_cell_store.sv @@
`default_nettype none

module cca_cell_store (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [cca_pkg::ADDR_BITS-1:0] wr_addr,
    input  wire logic [cca_pkg::OWNER_BITS-1:0] wr_data,
    input  wire logic                          rd_en,
    input  wire logic [cca_pkg::ADDR_BITS-1:0] rd_addr,
    output logic      [cca_pkg::OWNER_BITS-1:0] rd_data
);
    import cca_pkg::*;

    logic [OWNER_BITS-1:0] mem [CELL_COUNT];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/cca_run_unit.sv @@
`default_nettype none

module cca_run_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         restart,
    input  wire logic [1:0]                   fit_mode,
    input  wire logic [cca_pkg::LEN_BITS-1:0] want,
    input  wire cca_pkg::cca_step_t           step,
    output cca_pkg::cca_pick_t                pick
);
    import cca_pkg::*;

    logic [LEN_BITS-1:0]  run_len_reg,    run_len_next;
    logic [ADDR_BITS-1:0] run_start_reg,  run_start_next;
    logic [LEN_BITS-1:0]  pick_len_reg,   pick_len_next;
    logic [ADDR_BITS-1:0] pick_start_reg, pick_start_next;
    logic                 found_reg,      found_next;
    logic                 take;

    // Decide whether a run that has just ended replaces the current choice.
    always_comb begin
        take = 1'b0;
        if (run_len_reg >= want) begin
            if (!found_reg) begin
                take = 1'b1;
            end else begin
                unique case (fit_mode)
                    FIT_BEST:  take = run_len_reg < pick_len_reg;
                    FIT_WORST: take = run_len_reg > pick_len_reg;
                    default:   take = 1'b0;
                endcase
            end
        end
    end

    // Track the current free run and the chosen one, one cell per step.
    always_comb begin
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        pick_len_next   = pick_len_reg;
        pick_start_next = pick_start_reg;
        found_next      = found_reg;
        if (restart) begin
            run_len_next = '0;
            found_next   = 1'b0;
        end else if (step.valid) begin
            if (step.free_cell) begin
                if (run_len_reg == '0) begin
                    run_start_next = step.index[ADDR_BITS-1:0];
                end
                run_len_next = run_len_reg + LEN_BITS'(1);
            end else begin
                if (take) begin
                    found_next      = 1'b1;
                    pick_start_next = run_start_reg;
                    pick_len_next   = run_len_reg;
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_len_reg <= '0;
            found_reg   <= 1'b0;
        end else begin
            run_len_reg <= run_len_next;
            found_reg   <= found_next;
        end
        run_start_reg  <= run_start_next;
        pick_len_reg   <= pick_len_next;
        pick_start_reg <= pick_start_next;
    end

    assign pick.found = found_reg;
    assign pick.start = pick_start_reg;

endmodule

`default_nettype wire

@@ rtl/cca_checker.sv @@
`default_nettype none

module cca_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire cca_pkg::cca_rsp_t m_data
);
    import cca_pkg::*;

    // Reset leaves the block busy clearing and with no result pending.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block ready or result pending straight after reset");

    // A request is worked on alone: the block is busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("block ready again right after taking a request");

    // Failed results carry a zero start cell.
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != STAT_DONE) |-> m_data.start_cell == '0)
        else $error("non-zero start cell with a failing status");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

endmodule

bind contiguous_cell_allocator cca_checker u_cca_checker (.*);

`default_nettype wire
